### src/wli_pkg.sv
// Package for the waypoint linear interpolator: item structs and sizing constants.
// No dependencies. Used by the top level and by its checker.
package wli_pkg;

   localparam int COORD_W   = 32;
   localparam int SPACING_W = 31;
   localparam int MAX_STEPS = 64;
   // Step counter must be able to hold MAX_STEPS itself.
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int NUM_AXES  = 3;
   localparam int AX_W      = 2;
   // Coordinate difference magnitude: up to 2^32 - 1.
   localparam int MAG_W     = COORD_W + 1;
   localparam int PROD_W    = 2 * MAG_W;
   // Sum of three squares stays below 2^66.
   localparam int D2_W      = PROD_W;
   localparam int S2_W      = 2 * SPACING_W;
   // (k * spacing)^2 for k up to MAX_STEPS.
   localparam int SQ_W      = 2 * (SPACING_W + STEP_W);
   localparam int CNT_W     = $clog2(MAG_W);

   typedef struct packed {
      logic                      first_of_path;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      last_point;
      logic                      clamped;
   } rsp_type;

endpackage

### src/waypoint_linear_interpolator.sv
// Waypoint linear interpolator: splits each path segment into evenly spaced points.
// Depends on wli_pkg.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data) takes one waypoint per item.
//    req_stall is low only while the block is idle; one waypoint is in flight.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) gives 1..MAX_STEPS points per
//    waypoint; last_point marks the final one. The point is held in an output
//    register until rsp_stall is low; a stall simply extends the wait.
//  - csr channel (csr_valid / csr_ready / csr_data) writes the spacing register.
//    csr_ready is always high; write only while the block is idle.
//  - Pass-through waypoints (first of path, no previous point, spacing zero) show
//    on rsp in the cycle after acceptance.
//  - An interpolated segment is accepted, squared on the shared multiplier (SQUARE),
//    searched for its step count of 1..MAX_STEPS (SEARCH), divided bit-serially
//    (DIVIDE, 33 bits per axis, one axis at a time), then each point is built one
//    axis at a time (STEP) and held in the output register (EMIT).
//  - Synchronous reset clears spacing, the previous waypoint, the state and rsp_valid.
module waypoint_linear_interpolator
   import wli_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SPACING_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      IDLE, SQUARE, SEARCH, DIVIDE, STEP, EMIT
   } state_type;

   state_type               state_ff;
   logic [SPACING_W-1:0]    spacing_ff;
   logic                    have_prev_ff;
   logic [COORD_W-1:0]      prev_ff   [NUM_AXES];
   logic [COORD_W-1:0]      base_ff   [NUM_AXES];
   logic [MAG_W-1:0]        dmag_ff   [NUM_AXES];
   logic                    dneg_ff   [NUM_AXES];
   logic [MAG_W-1:0]        qd_ff     [NUM_AXES];
   logic [STEP_W-1:0]       rd_ff     [NUM_AXES];
   logic [MAG_W-1:0]        accq_ff   [NUM_AXES];
   logic [STEP_W-1:0]       accr_ff   [NUM_AXES];
   logic [COORD_W-1:0]      outc_ff   [NUM_AXES];
   logic [CNT_W-1:0]        cnt_ff;
   logic [AX_W-1:0]         ax_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [S2_W-1:0]         s2_ff;
   logic [D2_W-1:0]         d2_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [SQ_W-1:0]         inc_ff;
   logic [STEP_W-1:0]       k_ff;
   logic [STEP_W-1:0]       n_ff;
   logic [STEP_W-1:0]       j_ff;
   logic                    clamp_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff;
   logic [MAG_W-1:0]        num_ff;
   logic [STEP_W-1:0]       rem_ff;

   logic [COORD_W-1:0]      cur_in    [NUM_AXES];
   logic [MAG_W-1:0]        delta_in  [NUM_AXES];
   logic [MAG_W-1:0]        dmag_in   [NUM_AXES];
   logic                    req_acc;
   logic                    pass_in;
   logic [MAG_W-1:0]        mul_op;
   logic [PROD_W-1:0]       prod_in;
   logic [AX_W-1:0]         sq_sel;
   logic [STEP_W:0]         trial_in;
   logic                    qbit_in;
   logic [STEP_W-1:0]       rem_in;
   logic [STEP_W:0]         rsum_in;
   logic                    wrap_in;
   logic [STEP_W-1:0]       rnew_in;
   logic [MAG_W-1:0]        qnew_in;
   logic [COORD_W-1:0]      off_in;
   logic [COORD_W-1:0]      coord_in;
   logic                    found_in;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_data.out_x      = outc_ff[0];
   assign rsp_data.out_y      = outc_ff[1];
   assign rsp_data.out_z      = outc_ff[2];
   assign rsp_data.last_point = last_ff;
   assign rsp_data.clamped    = clamp_ff;

   assign cur_in[0] = req_data.in_x;
   assign cur_in[1] = req_data.in_y;
   assign cur_in[2] = req_data.in_z;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         delta_in[a] = {cur_in[a][COORD_W-1], cur_in[a]}
                     - {prev_ff[a][COORD_W-1], prev_ff[a]};
         dmag_in[a]  = delta_in[a][MAG_W-1] ? (~delta_in[a] + 1'b1) : delta_in[a];
      end
   end

   assign pass_in = req_data.first_of_path || !have_prev_ff || (spacing_ff == '0);

   // Shared multiplier: spacing first, then the three axis magnitudes.
   assign sq_sel  = cnt_ff[AX_W-1:0] - 1'b1;
   assign mul_op  = (cnt_ff[AX_W-1:0] == '0) ? {{(MAG_W-SPACING_W){1'b0}}, spacing_ff}
                                             : dmag_ff[sq_sel];
   assign prod_in = {{MAG_W{1'b0}}, mul_op} * {{MAG_W{1'b0}}, mul_op};

   assign found_in = (sq_ff >= {{(SQ_W-D2_W){1'b0}}, d2_ff});

   // One restoring-division bit per cycle.
   assign trial_in = {rem_ff, num_ff[MAG_W-1]};
   assign qbit_in  = (trial_in >= {1'b0, n_ff});
   always_comb begin
      if (qbit_in) begin
         rem_in = STEP_W'(trial_in - {1'b0, n_ff});
      end else begin
         rem_in = trial_in[STEP_W-1:0];
      end
   end

   // Running floor(j*D/n) as quotient plus remainder.
   assign rsum_in = {1'b0, accr_ff[ax_ff]} + {1'b0, rd_ff[ax_ff]};
   assign wrap_in = (rsum_in >= {1'b0, n_ff});
   always_comb begin
      if (wrap_in) begin
         rnew_in = STEP_W'(rsum_in - {1'b0, n_ff});
      end else begin
         rnew_in = rsum_in[STEP_W-1:0];
      end
   end
   assign qnew_in  = accq_ff[ax_ff] + qd_ff[ax_ff] + {{(MAG_W-1){1'b0}}, wrap_in};
   assign off_in   = qnew_in[COORD_W-1:0];
   assign coord_in = base_ff[ax_ff] + (dneg_ff[ax_ff] ? (~off_in + 1'b1) : off_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         spacing_ff   <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            prev_ff[a] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            spacing_ff <= csr_data;
         end
         case (state_ff)
            IDLE: begin
               if (req_acc) begin
                  have_prev_ff <= 1'b1;
                  for (int a = 0; a < NUM_AXES; a++) begin
                     prev_ff[a] <= cur_in[a];
                     base_ff[a] <= prev_ff[a];
                     dmag_ff[a] <= dmag_in[a];
                     dneg_ff[a] <= delta_in[a][MAG_W-1];
                  end
                  if (pass_in) begin
                     for (int a = 0; a < NUM_AXES; a++) begin
                        outc_ff[a] <= cur_in[a];
                     end
                     last_ff      <= 1'b1;
                     clamp_ff     <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= EMIT;
                  end else begin
                     cnt_ff   <= '0;
                     d2_ff    <= '0;
                     state_ff <= SQUARE;
                  end
               end
            end
            SQUARE: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  s2_ff <= prod_ff[S2_W-1:0];
               end else if (cnt_ff != '0) begin
                  d2_ff <= d2_ff + prod_ff;
               end
               if (cnt_ff == CNT_W'(NUM_AXES + 1)) begin
                  sq_ff    <= {{(SQ_W-S2_W){1'b0}}, s2_ff};
                  inc_ff   <= {{(SQ_W-S2_W){1'b0}}, s2_ff}
                            + {{(SQ_W-S2_W-1){1'b0}}, s2_ff, 1'b0};
                  k_ff     <= STEP_W'(1);
                  state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               if (found_in || (k_ff == STEP_W'(MAX_STEPS))) begin
                  n_ff     <= k_ff;
                  clamp_ff <= !found_in;
                  ax_ff    <= '0;
                  cnt_ff   <= '0;
                  num_ff   <= dmag_ff[0];
                  rem_ff   <= '0;
                  state_ff <= DIVIDE;
               end else begin
                  sq_ff  <= sq_ff + inc_ff;
                  inc_ff <= inc_ff + {{(SQ_W-S2_W-1){1'b0}}, s2_ff, 1'b0};
                  k_ff   <= k_ff + 1'b1;
               end
            end
            DIVIDE: begin
               if (cnt_ff == CNT_W'(MAG_W - 1)) begin
                  qd_ff[ax_ff] <= {num_ff[MAG_W-2:0], qbit_in};
                  rd_ff[ax_ff] <= rem_in;
                  cnt_ff       <= '0;
                  rem_ff       <= '0;
                  if (ax_ff == AX_W'(NUM_AXES - 1)) begin
                     ax_ff <= '0;
                     j_ff  <= STEP_W'(1);
                     for (int a = 0; a < NUM_AXES; a++) begin
                        accq_ff[a] <= '0;
                        accr_ff[a] <= '0;
                     end
                     state_ff <= STEP;
                  end else begin
                     ax_ff  <= ax_ff + 1'b1;
                     num_ff <= dmag_ff[ax_ff + 1'b1];
                  end
               end else begin
                  num_ff <= {num_ff[MAG_W-2:0], qbit_in};
                  rem_ff <= rem_in;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            STEP: begin
               accq_ff[ax_ff] <= qnew_in;
               accr_ff[ax_ff] <= rnew_in;
               outc_ff[ax_ff] <= coord_in;
               if (ax_ff == AX_W'(NUM_AXES - 1)) begin
                  ax_ff        <= '0;
                  last_ff      <= (j_ff == n_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= EMIT;
               end else begin
                  ax_ff <= ax_ff + 1'b1;
               end
            end
            EMIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_ff) begin
                     state_ff <= IDLE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= STEP;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### src/wli_checker.sv
// Port-level checks for the waypoint linear interpolator, bound to the top level.
// Depends on wli_pkg and waypoint_linear_interpolator.
module wli_checker
   import wli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data
);

   // A waiting point holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // No new waypoint is taken while points are still being delivered.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req open while rsp item pending");

   // A point that is not the last keeps the input closed.
   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_point |=> req_stall)
      else $error("input reopened before last point");

   // First waypoint of a path comes out unchanged in the next cycle.
   a_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.first_of_path |=>
         rsp_valid && rsp_data.last_point && !rsp_data.clamped &&
         rsp_data.out_x == $past(req_data.in_x) &&
         rsp_data.out_y == $past(req_data.in_y) &&
         rsp_data.out_z == $past(req_data.in_z))
      else $error("first waypoint not passed through");

endmodule

bind waypoint_linear_interpolator wli_checker u_wli_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### test/tb_waypoint_linear_interpolator.sv
// Testbench for waypoint_linear_interpolator: directed and random waypoints checked
// point by point against an in-bench predictor of the segment densification.
// Depends on wli_pkg and the waypoint_linear_interpolator RTL.
`timescale 1ns / 1ps

module tb_waypoint_linear_interpolator
   import wli_pkg::*;
();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 1500;
   localparam int SETTLE      = 10;
   localparam int END_WAIT    = 300;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 26;
   localparam int PRESSURE_PHASE = 6;

   localparam logic [SPACING_W-1:0] ONE_METRE   = 31'h0001_0000;
   localparam logic [SPACING_W-1:0] SPACING_MAX = 31'h7FFF_FFFF;
   localparam logic [COORD_W-1:0]   C_MAX       = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0]   C_MIN       = 32'h8000_0000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SPACING_W-1:0] csr_data  = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_rsp       = 1'b0;
   int          cycle_count    = 0;
   int          error_count    = 0;

   req_type waypoints_to_send[$];
   rsp_type pending_points[$];

   // predictor state
   logic [SPACING_W-1:0]      cur_spacing  = '0;
   logic signed [COORD_W-1:0] last_wp_x    = '0;
   logic signed [COORD_W-1:0] last_wp_y    = '0;
   logic signed [COORD_W-1:0] last_wp_z    = '0;
   logic                      have_last_wp = 1'b0;

   // generator state
   req_type gen_prev = '0;

   waypoint_linear_interpolator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // prev + trunc(step * delta / steps), rounding toward zero
   function automatic logic [COORD_W-1:0] lerp_axis(input longint base, input longint delta,
         input longint unsigned step, input longint unsigned steps);
      longint unsigned dist_abs;
      longint unsigned q;
      dist_abs = (delta < 0) ? -delta : delta;
      q = step * dist_abs / steps;
      return (delta < 0) ? COORD_W'(base - q) : COORD_W'(base + q);
   endfunction

   task automatic densify_segment(input req_type wp);
      longint       px, py, pz, dx, dy, dz;
      logic [127:0] ax, ay, az, dist_sq, reach;
      longint unsigned steps;
      logic         clamp;
      rsp_type      pt;
      px = last_wp_x;
      py = last_wp_y;
      pz = last_wp_z;
      dx = longint'($signed(wp.in_x)) - px;
      dy = longint'($signed(wp.in_y)) - py;
      dz = longint'($signed(wp.in_z)) - pz;
      ax = 128'((dx < 0) ? -dx : dx);
      ay = 128'((dy < 0) ? -dy : dy);
      az = 128'((dz < 0) ? -dz : dz);
      dist_sq = ax * ax + ay * ay + az * az;
      if (!wp.first_of_path && have_last_wp && cur_spacing != 0 &&
          128'(cur_spacing) * 128'(cur_spacing) < dist_sq) begin
         steps = MAX_STEPS;
         clamp = 1'b1;
         for (int k = 1; k <= MAX_STEPS; k++) begin
            reach = 128'(k) * 128'(cur_spacing);
            if (reach * reach >= dist_sq) begin
               steps = k;
               clamp = 1'b0;
               break;
            end
         end
         for (longint unsigned j = 1; j <= steps; j++) begin
            pt.out_x      = lerp_axis(px, dx, j, steps);
            pt.out_y      = lerp_axis(py, dy, j, steps);
            pt.out_z      = lerp_axis(pz, dz, j, steps);
            pt.last_point = (j == steps);
            pt.clamped    = clamp;
            pending_points = {pending_points, pt};
         end
      end else begin
         pt.out_x      = wp.in_x;
         pt.out_y      = wp.in_y;
         pt.out_z      = wp.in_z;
         pt.last_point = 1'b1;
         pt.clamped    = 1'b0;
         pending_points = {pending_points, pt};
      end
      last_wp_x    = wp.in_x;
      last_wp_y    = wp.in_y;
      last_wp_z    = wp.in_z;
      have_last_wp = 1'b1;
   endtask

   // driver: offer queued waypoints, hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            densify_segment(req_data);
         end
         if (!(req_valid && req_stall)) begin
            if (waypoints_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= waypoints_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [COORD_W-1:0] want,
         input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor: random stall, compare every accepted point
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected point, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = pending_points.pop_front();
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("out_z", want.out_z, rsp_data.out_z);
               check_field("last_point", want.last_point, rsp_data.last_point);
               check_field("clamped", want.clamped, rsp_data.clamped);
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d points outstanding",
                  $time, cycle_count, pending_points.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_spacing(input logic [SPACING_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cur_spacing  = value;
   endtask

   task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   task automatic add_waypoint(input logic first, input logic [COORD_W-1:0] x,
         input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      req_type wp;
      wp.first_of_path = first;
      wp.in_x = x;
      wp.in_y = y;
      wp.in_z = z;
      waypoints_to_send = {waypoints_to_send, wp};
      gen_prev = wp;
   endtask

   function automatic logic [COORD_W-1:0] rand_offset(input longint unsigned span);
      logic [COORD_W-1:0] m;
      m = $urandom_range(32'(span));
      return $urandom_range(1) ? -m : m;
   endfunction

   // mostly short hops scaled to the spacing, some long hops, some raw noise
   task automatic push_random(input int count);
      longint unsigned span;
      repeat (count) begin
         if ($urandom_range(99) < 15) begin
            add_waypoint(1'($urandom_range(1)), $urandom(), $urandom(), $urandom());
         end else begin
            if (cur_spacing == 0)
               span = 32'h7FFF_FFFF >> $urandom_range(31);
            else if ($urandom_range(9) == 0)
               span = 64'(cur_spacing) * $urandom_range(80, 20);
            else
               span = 64'(cur_spacing) * $urandom_range(12);
            if (span > 32'h7FFF_FFFF) span = 32'h7FFF_FFFF;
            add_waypoint($urandom_range(15) == 0,
                         gen_prev.in_x + rand_offset(span),
                         gen_prev.in_y + rand_offset(span),
                         gen_prev.in_z + rand_offset(span));
         end
      end
   endtask

   task automatic drain();
      while (waypoints_to_send.size() != 0 || req_valid || pending_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // no previous waypoint yet, zero hop, hop of exactly one spacing, short hops
      write_spacing(ONE_METRE);
      add_waypoint(1'b0, 32'h0001_8000, -32'sh0002_0000, 32'h0000_4000);
      add_waypoint(1'b0, 32'h0001_8000, -32'sh0002_0000, 32'h0000_4000);
      add_waypoint(1'b0, 32'h0002_8000, -32'sh0002_0000, 32'h0000_4000);
      add_waypoint(1'b0, 32'h0003_8001, -32'sh0002_0000, 32'h0000_4000);
      add_waypoint(1'b0, 32'h0002_0001, -32'sh0004_0000, 32'h0000_4000);
      add_waypoint(1'b0, 32'h0005_B334, -32'sh0005_3333, 32'h0000_C000);
      // new path at the corner, then full-range hops that saturate the step count
      add_waypoint(1'b1, C_MAX, C_MAX, C_MAX);
      add_waypoint(1'b0, C_MIN, C_MIN, C_MIN);
      add_waypoint(1'b0, C_MAX, C_MIN, 32'h0);
      add_waypoint(1'b1, 32'h0, 32'h0, 32'h0);
      drain();

      // smallest spacing: exactly MAX_STEPS points, then one step over
      write_spacing(31'd1);
      add_waypoint(1'b0, 32'd1, 32'd1, 32'd1);
      add_waypoint(1'b0, 32'd6, 32'd1, 32'd1);
      add_waypoint(1'b0, 32'd70, 32'd1, 32'd1);
      add_waypoint(1'b0, 32'd5, 32'd1, 32'd1);
      add_waypoint(1'b0, 32'd5, 32'd1, 32'd1);
      drain();

      write_spacing(SPACING_MAX);
      add_waypoint(1'b1, C_MIN, C_MIN, C_MIN);
      add_waypoint(1'b0, C_MAX, C_MAX, C_MAX);
      add_waypoint(1'b0, 32'h0, 32'h0, 32'h0);
      add_waypoint(1'b0, C_MAX, 32'h0, 32'h0);
      drain();

      // zero spacing disables interpolation
      write_spacing('0);
      add_waypoint(1'b0, C_MIN, C_MAX, 32'h1234_5678);
      add_waypoint(1'b0, 32'h0, 32'h0, 32'h0);
      add_waypoint(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0:       write_spacing(ONE_METRE);
            1:       write_spacing(SPACING_W'($urandom_range(32'h7FFF_FFFF, 1)
                                              >> $urandom_range(20)));
            2:       write_spacing(SPACING_MAX);
            3:       write_spacing(31'd1);
            4:       write_spacing('0);
            5:       write_spacing(SPACING_W'($urandom_range(4095, 1)));
            default: write_spacing(ONE_METRE >> $urandom_range(4));
         endcase
         if (phase == PRESSURE_PHASE) begin
            set_idle(0, 0);
            // long receiver hold-off while the sender keeps offering
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (LONG_HOLD) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end else begin
            case (phase % 4)
               0: set_idle(0, 0);
               1: set_idle(85, 0);
               2: set_idle(0, 85);
               default: set_idle(24, 24);
            endcase
         end
         push_random(PHASE_ITEMS);
         drain();
      end

      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
